FILE: src/assert_macros.svh
// Assertion macros shared by the prefix matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: src/ppm_pkg.sv
// Types, codes and character classes of the prefix policy matcher.
`default_nettype none

package ppm_pkg;

    localparam logic [1:0] MODE_PCHAR = 2'd0;
    localparam logic [1:0] MODE_DESC  = 2'd1;
    localparam logic [1:0] MODE_CMD   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] DEC_ALLOW  = 2'd0;
    localparam logic [1:0] DEC_PROMPT = 2'd1;
    localparam logic [1:0] DEC_FORBID = 2'd2;
    localparam logic [1:0] DEC_BAD    = 2'd3;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PAREN = 8'h28;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] entry;
        logic [5:0] position;
        logic [7:0] char_value;
        logic [5:0] prefix_length;
        logic [1:0] decision_in;
        logic [6:0] rule_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0] decision;
        logic       matched;
        logic [6:0] winning_rule;
        logic [5:0] match_length;
    } t_out_item;

    typedef struct packed {
        logic [5:0] len;
        logic [1:0] dec;
        logic [6:0] rule;
    } t_desc;

    typedef struct packed {
        logic       valid;
        logic       term;
        logic [7:0] c;
    } t_eval_ctl;

    typedef struct packed {
        logic en;
        logic val;
    } t_alive_wr;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        return (c == CH_END) || is_ws(c) || (c == CH_PIPE) || (c == CH_AMP) ||
               (c == CH_SEMI) || (c == CH_GT) || (c == CH_LT) || (c == CH_PAREN);
    endfunction

endpackage

`default_nettype wire

FILE: src/ppm_table.sv
// Prefix character, space mask, descriptor and still-match memories.
`default_nettype none

module ppm_table
    import ppm_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int PREFIX_LEN = 64,
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int PW = $clog2(PREFIX_LEN),
    localparam int AW = (ENTRIES * PREFIX_LEN > 1) ? $clog2(ENTRIES * PREFIX_LEN) : 1
) (
    input  wire                   i_clk,
    input  wire                   i_rd_en,
    input  wire  [EW-1:0]         i_rd_entry,
    input  wire  [PW-1:0]         i_rd_pos,
    output t_desc                 o_desc,
    output logic                  o_alive,
    output logic [7:0]            o_char,
    output logic [PREFIX_LEN-1:0] o_mask,
    input  wire                   i_cw_en,
    input  wire  [EW-1:0]         i_cw_entry,
    input  wire  [PW-1:0]         i_cw_pos,
    input  wire  [7:0]            i_cw_char,
    input  wire  [PREFIX_LEN-1:0] i_cw_mask,
    input  wire                   i_dw_en,
    input  wire  [EW-1:0]         i_dw_entry,
    input  t_desc                 i_dw_desc,
    input  wire                   i_aw_en,
    input  wire  [EW-1:0]         i_aw_entry,
    input  wire                   i_aw_val
);

    localparam logic [AW-1:0] PL_A = AW'(PREFIX_LEN);

    logic [7:0]            r_char_mem  [ENTRIES*PREFIX_LEN];
    logic [PREFIX_LEN-1:0] r_mask_mem  [ENTRIES];
    t_desc                 r_desc_mem  [ENTRIES];
    logic                  r_alive_mem [ENTRIES];

    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_cw_addr;

    assign w_rd_addr = AW'(AW'(i_rd_entry) * PL_A) + AW'(i_rd_pos);
    assign w_cw_addr = AW'(AW'(i_cw_entry) * PL_A) + AW'(i_cw_pos);

    always_ff @(posedge i_clk) begin
        if (i_cw_en) begin
            r_char_mem[w_cw_addr] <= i_cw_char;
        end
        if (i_rd_en) begin
            o_char <= r_char_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cw_en) begin
            r_mask_mem[i_cw_entry] <= i_cw_mask;
        end
        if (i_rd_en) begin
            o_mask <= r_mask_mem[i_rd_entry];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dw_en) begin
            r_desc_mem[i_dw_entry] <= i_dw_desc;
        end
        if (i_rd_en) begin
            o_desc <= r_desc_mem[i_rd_entry];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_aw_en) begin
            r_alive_mem[i_aw_entry] <= i_aw_val;
        end
        if (i_rd_en) begin
            o_alive <= r_alive_mem[i_rd_entry];
        end
    end

endmodule

`default_nettype wire

FILE: src/ppm_unit.sv
// Shared entry compare unit with the best-match registers.
`default_nettype none
`include "assert_macros.svh"

module ppm_unit
    import ppm_pkg::*;
#(
    parameter int PREFIX_LEN = 64,
    localparam int LW = $clog2(PREFIX_LEN + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_clear,
    input  t_eval_ctl             i_ctl,
    input  wire  [LW-1:0]         i_pos,
    input  t_desc                 i_desc,
    input  wire                   i_alive,
    input  wire  [7:0]            i_char,
    input  wire  [PREFIX_LEN-1:0] i_mask,
    output t_alive_wr             o_aw,
    output t_out_item             o_best
);

    logic       r_have;
    logic [5:0] r_len;
    logic [1:0] r_dec;
    logic [6:0] r_rule;

    logic                  w_live;
    logic                  w_before;
    logic                  w_at;
    logic                  w_kill;
    logic                  w_spaced;
    logic                  w_hit;
    logic                  w_better;
    logic [PREFIX_LEN-1:0] w_lmask;

    always_comb begin
        for (int j = 0; j < PREFIX_LEN; j++) begin
            w_lmask[j] = (32'(j) < 32'(i_desc.len));
        end
    end

    assign w_live   = i_ctl.valid && i_alive && (i_desc.len != 6'd0);
    assign w_before = 32'(i_pos) < 32'(i_desc.len);
    assign w_at     = 32'(i_pos) == 32'(i_desc.len);
    assign w_kill   = w_live && (!w_before || (i_ctl.c == CH_END) || (i_char != i_ctl.c));
    assign w_spaced = |(i_mask & w_lmask);
    assign w_hit    = w_live && w_at && (w_spaced || is_boundary(i_ctl.c));
    assign w_better = !r_have || (i_desc.len > r_len) ||
                      ((i_desc.len == r_len) && (i_desc.dec > r_dec));

    assign o_aw.en  = i_ctl.valid && (i_ctl.term || w_kill);
    assign o_aw.val = i_ctl.term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_have <= 1'b0;
            r_len  <= 6'd0;
            r_dec  <= DEC_PROMPT;
            r_rule <= 7'd0;
        end else if (w_hit && w_better) begin
            r_have <= 1'b1;
            r_len  <= i_desc.len;
            r_dec  <= i_desc.dec;
            r_rule <= i_desc.rule;
        end
    end

    assign o_best.decision     = r_have ? r_dec : DEC_PROMPT;
    assign o_best.matched      = r_have;
    assign o_best.winning_rule = r_have ? r_rule : 7'd0;
    assign o_best.match_length = r_have ? r_len : 6'd0;

    `ASSERT_CLK(a_have_drops_on_clear, $fell(r_have) |-> $past(i_clear), "match lost without clear")
    `ASSERT_CLK(a_best_grows, (r_have && $past(r_have) && !$past(i_clear)) |-> (r_len >= $past(r_len)), "best length shrank")

endmodule

`default_nettype wire

FILE: src/prefix_policy_matcher.sv
// Top level of the prefix policy matcher: sequencer, write decode and result register.
//
// Input channel i_in_valid / o_in_ready / i_in_data carries one request per accepted edge.
// Mode 0 stores a prefix character through a write step, mode 1 stores an entry
// descriptor and mode 3 is dropped. A mode 2 command character sweeps the whole
// table through one shared compare unit, one entry per cycle, then a drain
// step follows. Leading whitespace is dropped without a sweep.
// The end character (zero) runs the same sweep and one result step; its result
// shows on o_out_valid / o_out_data once the result step loads the output register.
// Throughput is set by the single read port of the entry memories.
// After reset a clearing pass over all entries marks every entry unused and
// restores every still-match bit; o_in_ready stays low meanwhile.
// When the receiver stalls, the result holds in the output register and new
// requests are still taken; a following end character waits in its result step
// until the register is free.
`default_nettype none
`include "assert_macros.svh"

module prefix_policy_matcher
    import ppm_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int PREFIX_LEN = 64,
    parameter int RULES      = 128
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(PREFIX_LEN);
    localparam int LW = $clog2(PREFIX_LEN + 1);
    localparam logic [EW-1:0] LAST_E = EW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_CHAR_WR = 6'b000100,
        S_SWEEP   = 6'b001000,
        S_DRAIN   = 6'b010000,
        S_RESULT  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [EW-1:0]   r_idx, n_idx;
    logic            r_b_valid, n_b_valid;
    logic [EW-1:0]   r_b_idx, n_b_idx;
    logic [LW-1:0]   r_pos, n_pos;
    logic            r_skip, n_skip;
    logic            r_term, n_term;
    logic [7:0]      r_c, n_c;
    logic            r_cw_ok, n_cw_ok;
    logic [EW-1:0]   r_cw_entry, n_cw_entry;
    logic [PW-1:0]   r_cw_pos, n_cw_pos;
    logic [7:0]      r_cw_char, n_cw_char;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic                  w_acc;
    logic                  w_ent_ok;
    logic                  w_pos_ok;
    t_desc                 w_new_desc;
    logic                  w_rd_en;
    logic [EW-1:0]         w_rd_entry;
    logic [PW-1:0]         w_rd_pos;
    logic                  w_dw_en;
    logic [EW-1:0]         w_dw_entry;
    t_desc                 w_dw_desc;
    logic                  w_aw_en;
    logic [EW-1:0]         w_aw_entry;
    logic                  w_aw_val;
    logic [PREFIX_LEN-1:0] w_cw_mask;
    logic                  w_clear;
    t_desc                 tb_desc;
    logic                  tb_alive;
    logic [7:0]            tb_char;
    logic [PREFIX_LEN-1:0] tb_mask;
    t_eval_ctl             w_ctl;
    t_alive_wr             w_aw;
    t_out_item             w_best;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_ent_ok   = 32'(i_in_data.entry) < ENTRIES;
    assign w_pos_ok   = 32'(i_in_data.position) < PREFIX_LEN;

    always_comb begin
        w_new_desc.len  = (32'(i_in_data.prefix_length) > PREFIX_LEN) ?
                          6'(PREFIX_LEN) : i_in_data.prefix_length;
        w_new_desc.dec  = (i_in_data.decision_in == DEC_BAD) ? DEC_FORBID :
                          i_in_data.decision_in;
        w_new_desc.rule = (32'(i_in_data.rule_number) > RULES - 1) ?
                          7'(RULES - 1) : i_in_data.rule_number;
    end

    always_comb begin
        w_rd_en    = (r_state == S_SWEEP) || (w_acc && (i_in_data.mode == MODE_PCHAR));
        w_rd_entry = (r_state == S_SWEEP) ? r_idx : EW'(i_in_data.entry);
        w_rd_pos   = (r_state == S_SWEEP) ? r_pos[PW-1:0] : PW'(i_in_data.position);
    end

    always_comb begin
        w_dw_en    = (r_state == S_CLEAR) ||
                     (w_acc && (i_in_data.mode == MODE_DESC) && w_ent_ok);
        w_dw_entry = (r_state == S_CLEAR) ? r_idx : EW'(i_in_data.entry);
        w_dw_desc  = (r_state == S_CLEAR) ? t_desc'('0) : w_new_desc;
    end

    always_comb begin
        w_aw_en    = (r_state == S_CLEAR) || w_aw.en;
        w_aw_entry = (r_state == S_CLEAR) ? r_idx : r_b_idx;
        w_aw_val   = (r_state == S_CLEAR) ? 1'b1 : w_aw.val;
    end

    always_comb begin
        w_cw_mask           = tb_mask;
        w_cw_mask[r_cw_pos] = (r_cw_char == CH_SPACE);
    end

    assign w_ctl.valid = r_b_valid;
    assign w_ctl.term  = r_term;
    assign w_ctl.c     = r_c;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_b_valid   = 1'b0;
        n_b_idx     = r_b_idx;
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_term      = r_term;
        n_c         = r_c;
        n_cw_ok     = r_cw_ok;
        n_cw_entry  = r_cw_entry;
        n_cw_pos    = r_cw_pos;
        n_cw_char   = r_cw_char;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_clear     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_E) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    priority if (i_in_data.mode == MODE_PCHAR) begin
                        n_cw_ok    = w_ent_ok && w_pos_ok;
                        n_cw_entry = EW'(i_in_data.entry);
                        n_cw_pos   = PW'(i_in_data.position);
                        n_cw_char  = i_in_data.char_value;
                        n_state    = S_CHAR_WR;
                    end else if (i_in_data.mode == MODE_CMD) begin
                        if (!(r_skip && (i_in_data.char_value != CH_END) &&
                              is_ws(i_in_data.char_value))) begin
                            n_skip  = 1'b0;
                            n_c     = i_in_data.char_value;
                            n_term  = (i_in_data.char_value == CH_END);
                            n_idx   = '0;
                            n_state = S_SWEEP;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CHAR_WR: begin
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                n_b_valid = 1'b1;
                n_b_idx   = r_idx;
                if (r_idx == LAST_E) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_term) begin
                    n_state = S_RESULT;
                end else begin
                    if (32'(r_pos) < PREFIX_LEN) begin
                        n_pos = r_pos + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = w_best;
                    w_clear     = 1'b1;
                    n_pos       = '0;
                    n_skip      = 1'b1;
                    n_term      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_b_valid   <= 1'b0;
            r_pos       <= '0;
            r_skip      <= 1'b1;
            r_term      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_b_valid   <= n_b_valid;
            r_pos       <= n_pos;
            r_skip      <= n_skip;
            r_term      <= n_term;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_idx    <= n_b_idx;
        r_c        <= n_c;
        r_cw_ok    <= n_cw_ok;
        r_cw_entry <= n_cw_entry;
        r_cw_pos   <= n_cw_pos;
        r_cw_char  <= n_cw_char;
        r_out      <= n_out;
    end

    ppm_table #(
        .ENTRIES    (ENTRIES),
        .PREFIX_LEN (PREFIX_LEN)
    ) u_table (
        .i_clk      (i_clk),
        .i_rd_en    (w_rd_en),
        .i_rd_entry (w_rd_entry),
        .i_rd_pos   (w_rd_pos),
        .o_desc     (tb_desc),
        .o_alive    (tb_alive),
        .o_char     (tb_char),
        .o_mask     (tb_mask),
        .i_cw_en    ((r_state == S_CHAR_WR) && r_cw_ok),
        .i_cw_entry (r_cw_entry),
        .i_cw_pos   (r_cw_pos),
        .i_cw_char  (r_cw_char),
        .i_cw_mask  (w_cw_mask),
        .i_dw_en    (w_dw_en),
        .i_dw_entry (w_dw_entry),
        .i_dw_desc  (w_dw_desc),
        .i_aw_en    (w_aw_en),
        .i_aw_entry (w_aw_entry),
        .i_aw_val   (w_aw_val)
    );

    ppm_unit #(
        .PREFIX_LEN (PREFIX_LEN)
    ) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_ctl   (w_ctl),
        .i_pos   (r_pos),
        .i_desc  (tb_desc),
        .i_alive (tb_alive),
        .i_char  (tb_char),
        .i_mask  (tb_mask),
        .o_aw    (w_aw),
        .o_best  (w_best)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEVER(a_ready_while_sweep, r_b_valid && o_in_ready, "request taken during a sweep")
    `ASSERT_CLK(a_result_only_at_end, (r_state == S_RESULT) |-> r_term, "result step without end")
    `ASSERT_CLK(a_out_from_result, $rose(r_out_valid) |-> $past(r_state == S_RESULT), "result without result step")
    `ASSERT_CLK(a_alive_wr_source, w_aw_en |-> (r_b_valid || (r_state == S_CLEAR)), "stray still-match write")

endmodule

`default_nettype wire

FILE: dv/tb_prefix_policy_matcher.sv
// Testbench for prefix_policy_matcher: directed and random request streams checked against a predictor.
`timescale 1ns / 100ps

module tb_prefix_policy_matcher;
    import ppm_pkg::*;

    localparam int ENTRIES      = 256;
    localparam int PREFIX_LEN   = 64;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = ENTRIES + 16;

    localparam logic [7:0] SEP_CHARS [0:11] = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR,
                                                CH_PIPE, CH_AMP, CH_SEMI, CH_GT, CH_LT, CH_PAREN};

    typedef logic [7:0] t_bytes [$];

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    bit idle_on = 1'b1;
    int mismatches = 0;
    int requests_sent = 0;
    int results_due = 0;
    int results_checked = 0;
    int hits = 0;
    int unsigned cycles = 0;

    // table and command state of the predictor
    bit [7:0] pfx_char [ENTRIES][PREFIX_LEN];
    bit       pfx_wr   [ENTRIES][PREFIX_LEN];
    bit [5:0] pfx_len  [ENTRIES];
    bit [1:0] pfx_dec  [ENTRIES];
    bit [6:0] pfx_rule [ENTRIES];
    bit       pfx_live [ENTRIES] = '{default: 1'b1};
    int       cmd_pos  = 0;
    bit       lead_ws  = 1'b1;
    int       top_len  = 0;
    bit [1:0] top_dec  = DEC_PROMPT;
    bit [6:0] top_rule = '0;
    bit       top_hit  = 1'b0;

    t_out_item pending_verdicts [$];

    prefix_policy_matcher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     pending_verdicts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit ends_word(input logic [7:0] c);
        return (c == CH_END) || ws_char(c) || c == CH_PIPE || c == CH_AMP ||
               c == CH_SEMI || c == CH_GT || c == CH_LT || c == CH_PAREN;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic policy_step(input t_in_item it);
        t_out_item verdict;
        logic [7:0] c;
        bit spaced;
        int len;
        c = it.char_value;
        case (it.mode)
            MODE_PCHAR: begin
                pfx_char[it.entry][it.position] = c;
                pfx_wr[it.entry][it.position] = 1'b1;
            end
            MODE_DESC: begin
                pfx_len[it.entry] = it.prefix_length;
                pfx_dec[it.entry] = (it.decision_in == DEC_BAD) ? DEC_FORBID : it.decision_in;
                pfx_rule[it.entry] = it.rule_number;
            end
            MODE_CMD: begin
                if (!(lead_ws && c != CH_END && ws_char(c))) begin
                    lead_ws = 1'b0;
                    for (int e = 0; e < ENTRIES; e++) begin
                        len = pfx_len[e];
                        if (pfx_live[e] && len != 0) begin
                            if (cmd_pos < len) begin
                                if (c == CH_END || pfx_char[e][cmd_pos] != c) begin
                                    pfx_live[e] = 1'b0;
                                end
                            end else begin
                                if (cmd_pos == len) begin
                                    spaced = 1'b0;
                                    for (int k = 0; k < len; k++) begin
                                        if (pfx_char[e][k] == CH_SPACE) spaced = 1'b1;
                                    end
                                    if ((spaced || ends_word(c)) && (!top_hit || len > top_len ||
                                        (len == top_len && pfx_dec[e] > top_dec))) begin
                                        top_hit  = 1'b1;
                                        top_len  = len;
                                        top_dec  = pfx_dec[e];
                                        top_rule = pfx_rule[e];
                                    end
                                end
                                pfx_live[e] = 1'b0;
                            end
                        end
                    end
                    if (c != CH_END) begin
                        if (cmd_pos < PREFIX_LEN) cmd_pos++;
                    end else begin
                        verdict.decision     = top_hit ? top_dec : DEC_PROMPT;
                        verdict.matched      = top_hit;
                        verdict.winning_rule = top_hit ? top_rule : '0;
                        verdict.match_length = top_hit ? 6'(top_len) : '0;
                        pending_verdicts.push_back(verdict);
                        results_due++;
                        if (top_hit) hits++;
                        pfx_live = '{default: 1'b1};
                        cmd_pos  = 0;
                        lead_ws  = 1'b1;
                        top_len  = 0;
                        top_dec  = DEC_PROMPT;
                        top_rule = '0;
                        top_hit  = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        policy_step(it);
        if (it.mode != MODE_NONE) requests_sent++;
    endtask

    function automatic t_in_item random_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic logic [7:0] pick_char(input bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return "a";
        if (r < 65) return "b";
        if (r < 80) return CH_SPACE;
        if (r < 85) return "c";
        if (r < 90) return SEP_CHARS[$urandom_range(0, 11)];
        if (r < 98) return 8'($urandom_range(1, 255));
        return allow_zero ? CH_END : "x";
    endfunction

    function automatic t_bytes to_bytes(input string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic write_char(input int e, input int pos, input logic [7:0] c);
        t_in_item it;
        it = random_item();
        it.mode       = MODE_PCHAR;
        it.entry      = 8'(e);
        it.position   = 6'(pos);
        it.char_value = c;
        send_request(it);
    endtask

    task automatic write_desc(input int e, input int len, input logic [1:0] dec,
                              input logic [6:0] rule);
        t_in_item it;
        it = random_item();
        it.mode          = MODE_DESC;
        it.entry         = 8'(e);
        it.prefix_length = 6'(len);
        it.decision_in   = dec;
        it.rule_number   = rule;
        send_request(it);
    endtask

    task automatic load_prefix(input int e, input string s, input logic [1:0] dec,
                               input logic [6:0] rule);
        for (int k = 0; k < s.len(); k++) write_char(e, k, s[k]);
        write_desc(e, s.len(), dec, rule);
    endtask

    task automatic send_cmd_char(input logic [7:0] c);
        t_in_item it;
        it = random_item();
        it.mode       = MODE_CMD;
        it.char_value = c;
        send_request(it);
    endtask

    task automatic random_side_write();
        t_in_item it;
        int e;
        int run;
        it = random_item();
        e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES - 1) : $urandom_range(0, 7);
        case ($urandom_range(0, 2))
            0: begin
                it.mode       = MODE_PCHAR;
                it.entry      = 8'(e);
                it.char_value = pick_char(1'b1);
            end
            1: begin
                // keep the length within characters already written
                run = 0;
                while (run < PREFIX_LEN - 1 && pfx_wr[e][run]) run++;
                it.mode          = MODE_DESC;
                it.entry         = 8'(e);
                it.prefix_length = 6'($urandom_range(0, run));
            end
            default: it.mode = MODE_NONE;
        endcase
        send_request(it);
    endtask

    task automatic send_command(input t_bytes cmd, input bit mix);
        foreach (cmd[i]) begin
            if (mix && $urandom_range(0, 19) == 0) random_side_write();
            send_cmd_char(cmd[i]);
        end
        send_cmd_char(CH_END);
    endtask

    task automatic test_empty_command();
        send_command(to_bytes(" "), 1'b0);
    endtask

    task automatic test_boundary_and_tie();
        load_prefix(0, "ls", DEC_ALLOW, 7'd5);
        load_prefix(ENTRIES - 1, "l", DEC_BAD, 7'd127);
        load_prefix(2, "ls", DEC_FORBID, 7'd9);
        send_command(to_bytes("ls|"), 1'b0);
    endtask

    task automatic test_spaced_prefix();
        load_prefix(3, "l ", DEC_PROMPT, 7'd3);
        send_command(to_bytes("l x"), 1'b0);
    endtask

    task automatic test_special_cases();
        t_in_item it;
        it = random_item();
        it.mode = MODE_NONE;
        send_request(it);
        write_char(4, 0, CH_END);
        write_desc(4, 1, DEC_ALLOW, 7'd0);
        send_cmd_char("l");
        write_desc(2, 0, DEC_BAD, 7'd127);
        send_cmd_char(CH_END);
    endtask

    task automatic test_random_traffic();
        int start;
        int e;
        int len;
        int lead;
        int pick;
        t_bytes cmd;
        start = requests_sent;
        while (requests_sent - start < RANDOM_ITEMS) begin
            if (requests_sent - start > RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES - 1)
                                                    : $urandom_range(0, 7);
                    case ($urandom_range(0, 19))
                        0, 1:    len = 0;
                        2:       len = $urandom_range(0, 1) ? 63 : $urandom_range(6, 63);
                        default: len = $urandom_range(1, 5);
                    endcase
                    for (int k = 0; k < len; k++) write_char(e, k, pick_char(1'b1));
                    write_desc(e, len, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
                end
            end
            pick = -1;
            e = $urandom_range(0, ENTRIES - 1);
            for (int i = 0; i < ENTRIES && pick < 0; i++) begin
                if (pfx_len[(e + i) % ENTRIES] != 0) pick = (e + i) % ENTRIES;
            end
            cmd = {};
            if (pick >= 0 && $urandom_range(0, 3) != 0) begin
                lead = 0;
                if ($urandom_range(0, 3) == 0) begin
                    lead = $urandom_range(1, 2);
                    repeat (lead) cmd.push_back(SEP_CHARS[$urandom_range(0, 5)]);
                end
                len = pfx_len[pick];
                if ($urandom_range(0, 5) == 0) len = $urandom_range(0, len - 1);
                for (int k = 0; k < len; k++) cmd.push_back(pfx_char[pick][k]);
                if (len > 0 && $urandom_range(0, 5) == 0) begin
                    cmd[lead + $urandom_range(0, len - 1)] = pick_char(1'b0);
                end
                case ($urandom_range(0, 2))
                    0: ;
                    1: cmd.push_back(SEP_CHARS[$urandom_range(0, 11)]);
                    default: cmd.push_back(pick_char(1'b0));
                endcase
                repeat ($urandom_range(0, 3)) cmd.push_back(pick_char(1'b0));
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    cmd.push_back($urandom_range(0, 1) ? pick_char(1'b0)
                                                       : 8'($urandom_range(1, 255)));
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                while (cmd.size() < PREFIX_LEN + 2) cmd.push_back(pick_char(1'b0));
            end
            send_command(cmd, 1'b1);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no command end pending");
            end else begin
                want = pending_verdicts.pop_front();
                results_checked++;
                if (out_data.decision !== want.decision)
                    report_mismatch($sformatf("decision got %0d want %0d",
                                              out_data.decision, want.decision));
                if (out_data.matched !== want.matched)
                    report_mismatch($sformatf("matched got %0d want %0d",
                                              out_data.matched, want.matched));
                if (out_data.winning_rule !== want.winning_rule)
                    report_mismatch($sformatf("winning_rule got %0d want %0d",
                                              out_data.winning_rule, want.winning_rule));
                if (out_data.match_length !== want.match_length)
                    report_mismatch($sformatf("match_length got %0d want %0d",
                                              out_data.match_length, want.match_length));
            end
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_command();
        test_boundary_and_tie();
        test_spaced_prefix();
        test_special_cases();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests; checked %0d command results, %0d with a winning prefix.",
                 requests_sent, results_checked, hits);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
